// ===== rtl/pwmpt_pkg.sv =====
// Shared types and constants for the PWM prescale and tick calculator.
package pwmpt_pkg;

   // Fixed field widths
   localparam int US_BITS    = 24;
   localparam int CLK_BITS   = 28;
   localparam int P_BITS     = 3;
   localparam int TICK_BITS  = 16;
   localparam int PROD_BITS  = US_BITS + CLK_BITS;

   // One million is 64 * 15625; x / 15625 is (x * RECIP_15625) >> 44 for x below 2^30
   localparam logic [30:0]          RECIP_15625 = 31'd1125899907;
   // Full-scale duty value
   localparam logic [TICK_BITS-1:0] SCALE_FULL = 16'hFFFF;
   // Any product at or above this gives more than 65535 ticks
   localparam logic [PROD_BITS-1:0] DUTY_LIMIT = 52'd65536000000;
   localparam logic [CLK_BITS-1:0]  CLK_RESET  = 28'd48000000;

   // Request as it sits in the queue
   typedef struct packed {
      logic [US_BITS-1:0] period_micros;
      logic [US_BITS-1:0] pulse_micros;
      logic               pulse_zero;
   } pwmpt_item_type;

   // Finished result
   typedef struct packed {
      logic [P_BITS-1:0]    prescale_log2;
      logic [TICK_BITS-1:0] period_ticks;
      logic [TICK_BITS-1:0] duty_ticks;
      logic [TICK_BITS-1:0] duty_scaled;
      logic                 prescale_changed;
   } pwmpt_result_type;

endpackage

// ===== rtl/pwm_prescale_and_tick_calc.sv =====
// Top level: register port, front end, request queue and compute engine.
// Each request goes through a prescaler search, a period divide (skipped when saturated),
// the duty steps and the duty scaling divide; the result then waits until it is taken.
// The engine handles one request at a time.
// Reset (synchronous): queue empty, no result held, applied prescaler 0,
// source clock register 48000000.
module pwm_prescale_and_tick_calc #(
   parameter int COUNTER_MAX    = 65535,
   parameter int PRESCALE_STEPS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [23:0] req_period_micros,
   input  logic [23:0] req_pulse_micros,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_prescale_log2,
   output logic [15:0] rsp_period_ticks,
   output logic [15:0] rsp_duty_ticks,
   output logic [15:0] rsp_duty_scaled,
   output logic        rsp_prescale_changed,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [pwmpt_pkg::CLK_BITS-1:0] clk_hz_ff, clk_hz_in;
   logic                           push, pop, full, not_empty;
   pwmpt_pkg::pwmpt_item_type      push_item, head;
   pwmpt_pkg::pwmpt_result_type    res;

   // Register port: one clock register, selected whenever address bit 2 is low (indexes 0 to 3)
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {4'd0, clk_hz_ff};

   always_comb begin
      clk_hz_in = clk_hz_ff;
      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         clk_hz_in = csr_pwdata[pwmpt_pkg::CLK_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= pwmpt_pkg::CLK_RESET;
      end else begin
         clk_hz_ff <= clk_hz_in;
      end
   end

   pwmpt_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_period_micros (req_period_micros),
      .req_pulse_micros  (req_pulse_micros),
      .queue_full        (full),
      .push              (push),
      .push_item         (push_item)
   );

   pwmpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head      (head)
   );

   pwmpt_engine #(
      .COUNTER_MAX    (COUNTER_MAX),
      .PRESCALE_STEPS (PRESCALE_STEPS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .clk_hz      (clk_hz_ff),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .res_valid   (rsp_valid),
      .res         (res),
      .res_ready   (rsp_ready)
   );

   assign rsp_prescale_log2    = res.prescale_log2;
   assign rsp_period_ticks     = res.period_ticks;
   assign rsp_duty_ticks       = res.duty_ticks;
   assign rsp_duty_scaled      = res.duty_scaled;
   assign rsp_prescale_changed = res.prescale_changed;

   // Duty never exceeds the period
   a_duty_le_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_ticks <= rsp_period_ticks)
      else $error("duty ticks above period ticks");

   // Period is clamped to at least one tick
   a_period_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_period_ticks != 16'd0)
      else $error("period ticks zero");

   // Full duty scales to full range
   a_full_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_duty_ticks == rsp_period_ticks |-> rsp_duty_scaled == 16'hFFFF)
      else $error("full duty not scaled to full range");

   // Queue pops only when it holds a request
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

endmodule

// ===== rtl/pwmpt_front.sv =====
// Front end: accepts requests and tags them before they enter the queue.
module pwmpt_front (
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [pwmpt_pkg::US_BITS-1:0]    req_period_micros,
   input  logic [pwmpt_pkg::US_BITS-1:0]    req_pulse_micros,
   input  logic                             queue_full,
   output logic                             push,
   output pwmpt_pkg::pwmpt_item_type        push_item
);

   // Take a request whenever the queue has room
   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // Zero pulse needs no duty division in the back end
   always_comb begin
      push_item.period_micros = req_period_micros;
      push_item.pulse_micros  = req_pulse_micros;
      push_item.pulse_zero    = (req_pulse_micros == '0);
   end

endmodule

// ===== rtl/pwmpt_queue.sv =====
// Two-entry request queue between the front end and the compute engine.
module pwmpt_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  pwmpt_pkg::pwmpt_item_type push_item,
   input  logic                      pop,
   output logic                      full,
   output logic                      not_empty,
   output pwmpt_pkg::pwmpt_item_type head
);

   pwmpt_pkg::pwmpt_item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = mem_ff[rd_ptr_ff];

   // Pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/pwmpt_engine.sv =====
// Back end: prescaler search, tick divisions and duty scaling, one request at a time.
module pwmpt_engine #(
   parameter int COUNTER_MAX    = 65535,
   parameter int PRESCALE_STEPS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [pwmpt_pkg::CLK_BITS-1:0]       clk_hz,
   input  logic                                 q_not_empty,
   input  pwmpt_pkg::pwmpt_item_type            q_head,
   output logic                                 q_pop,
   output logic                                 res_valid,
   output pwmpt_pkg::pwmpt_result_type          res,
   input  logic                                 res_ready
);

   localparam int PB = pwmpt_pkg::P_BITS;
   localparam int TB = pwmpt_pkg::TICK_BITS;
   localparam int WB = pwmpt_pkg::PROD_BITS;
   localparam logic [WB-1:0] PERIOD_LIMIT =
      WB'((64'(COUNTER_MAX) + 64'd1) * 64'd1000000);
   localparam logic [PB-1:0] LAST_P = PB'(PRESCALE_STEPS - 1);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_SMUL = 11'b000_0000_0010,
      S_SCMP = 11'b000_0000_0100,
      S_PDIV = 11'b000_0000_1000,
      S_DMUL = 11'b000_0001_0000,
      S_DCMP = 11'b000_0010_0000,
      S_DDIV = 11'b000_0100_0000,
      S_NMUL = 11'b000_1000_0000,
      S_NLD  = 11'b001_0000_0000,
      S_NDIV = 11'b010_0000_0000,
      S_DONE = 11'b100_0000_0000
   } state_type;

   state_type                   state_ff, state_in;
   pwmpt_pkg::pwmpt_item_type   item_ff, item_in;
   logic [PB-1:0]               p_ff, p_in;
   logic [WB-1:0]               prod_ff, prod_in;
   logic [TB-1:0]               pticks_ff, pticks_in;
   logic [TB-1:0]               dticks_ff, dticks_in;
   logic [TB-1:0]               scaled_ff, scaled_in;
   logic [19:0]                 rem_ff, rem_in;
   logic [16:0]                 lo_ff, lo_in;
   logic [16:0]                 quo_ff, quo_in;
   logic [4:0]                  cnt_ff, cnt_in;
   logic [19:0]                 dvs_ff, dvs_in;
   logic [PB-1:0]               applied_ff, applied_in;
   logic                        out_valid_ff, out_valid_in;
   pwmpt_pkg::pwmpt_result_type out_ff, out_in;

   logic [pwmpt_pkg::CLK_BITS-1:0] clk_shift;
   logic [20:0]                    trial;
   logic                           qbit;
   logic [16:0]                    quo_next;
   logic [TB-1:0]                  qlow;
   logic [60:0]                    recip_prod;
   logic [TB-1:0]                  mega_q;

   assign clk_shift = clk_hz >> p_ff;
   assign res_valid = out_valid_ff;
   assign res       = out_ff;

   // Divide by one million: drop six bits, then reciprocal multiply for 15625.
   // Products reaching here are below 2^36, so the quotient fits 16 bits.
   assign recip_prod = prod_ff[35:6] * pwmpt_pkg::RECIP_15625;
   assign mega_q     = recip_prod[59:44];

   // One restoring divide step
   assign trial    = {rem_ff, lo_ff[16]};
   assign qbit     = (trial >= {1'b0, dvs_ff});
   assign quo_next = {quo_ff[15:0], qbit};
   assign qlow     = quo_next[TB-1:0];

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      p_in         = p_ff;
      prod_in      = prod_ff;
      pticks_in    = pticks_ff;
      dticks_in    = dticks_ff;
      scaled_in    = scaled_ff;
      rem_in       = rem_ff;
      lo_in        = lo_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      dvs_in       = dvs_ff;
      applied_in   = applied_ff;
      out_valid_in = out_valid_ff && !res_ready;
      out_in       = out_ff;
      q_pop        = 1'b0;

      // Divider stepping for the duty scaling
      if (state_ff == S_NDIV) begin
         rem_in = qbit ? 20'(trial - {1'b0, dvs_ff}) : trial[19:0];
         lo_in  = {lo_ff[15:0], 1'b0};
         quo_in = quo_next;
         cnt_in = cnt_ff - 5'd1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               item_in  = q_head;
               p_in     = '0;
               state_in = S_SMUL;
            end
         end
         S_SMUL: begin
            prod_in  = WB'(item_ff.period_micros * clk_shift);
            state_in = S_SCMP;
         end
         S_SCMP: begin
            if (prod_ff < PERIOD_LIMIT) begin
               // Fits: divide by one million next
               state_in = S_PDIV;
            end else if (p_ff == LAST_P) begin
               pticks_in = TB'(COUNTER_MAX);
               state_in  = S_DMUL;
            end else begin
               p_in     = p_ff + PB'(1);
               state_in = S_SMUL;
            end
         end
         S_PDIV: begin
            pticks_in = (mega_q == '0) ? TB'(1) : mega_q;
            state_in  = S_DMUL;
         end
         S_DMUL: begin
            prod_in = WB'(item_ff.pulse_micros * clk_shift);
            if (item_ff.pulse_zero) begin
               dticks_in = '0;
               state_in  = S_NMUL;
            end else begin
               state_in = S_DCMP;
            end
         end
         S_DCMP: begin
            if (prod_ff >= pwmpt_pkg::DUTY_LIMIT) begin
               dticks_in = pticks_ff;
               state_in  = S_NMUL;
            end else begin
               state_in = S_DDIV;
            end
         end
         S_DDIV: begin
            dticks_in = (mega_q > pticks_ff) ? pticks_ff : mega_q;
            state_in  = S_NMUL;
         end
         S_NMUL: begin
            prod_in  = WB'(dticks_ff * pwmpt_pkg::SCALE_FULL);
            state_in = S_NLD;
         end
         S_NLD: begin
            rem_in   = {4'd0, prod_ff[31:16]};
            lo_in    = {prod_ff[15:0], 1'b0};
            quo_in   = '0;
            cnt_in   = 5'd16;
            dvs_in   = {4'd0, pticks_ff};
            state_in = S_NDIV;
         end
         S_NDIV: begin
            if (cnt_ff == 5'd1) begin
               scaled_in = qlow;
               state_in  = S_DONE;
            end
         end
         S_DONE: begin
            if (!out_valid_ff || res_ready) begin
               out_in.prescale_log2    = p_ff;
               out_in.period_ticks     = pticks_ff;
               out_in.duty_ticks       = dticks_ff;
               out_in.duty_scaled      = scaled_ff;
               out_in.prescale_changed = (p_ff != applied_ff);
               applied_in              = p_ff;
               out_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         applied_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         applied_ff   <= applied_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Datapath, no reset
   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      p_ff      <= p_in;
      prod_ff   <= prod_in;
      pticks_ff <= pticks_in;
      dticks_ff <= dticks_in;
      scaled_ff <= scaled_in;
      rem_ff    <= rem_in;
      lo_ff     <= lo_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      dvs_ff    <= dvs_in;
      out_ff    <= out_in;
   end

endmodule

// ===== verif/testbench.sv =====
// Testbench for the PWM prescale and tick calculator: directed table, random requests, predictor.
module testbench;

   localparam int CNT_MAX    = 65535;
   localparam int MAX_CYCLES = 2000000;
   localparam int N_RANDOM   = 1530;
   localparam logic [2:0] REG_SOURCE_CLOCK = 3'd0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [23:0] req_period_micros = '0;
   logic [23:0] req_pulse_micros = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_prescale_log2;
   logic [15:0] rsp_period_ticks;
   logic [15:0] rsp_duty_ticks;
   logic [15:0] rsp_duty_scaled;
   logic        rsp_prescale_changed;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pwm_prescale_and_tick_calc i_dut (.*);

   always #2 clock = ~clock;

   // Predictor state
   logic [27:0] model_clock_hz;
   logic [2:0]  model_prescale;
   pwmpt_pkg::pwmpt_result_type expected_q[$];
   int          mismatches = 0;
   int          cycles = 0;
   int          rsp_gap = 0;
   bit          rsp_idle_off = 1'b0;

   // Compute the expected result for one request and advance the prescaler state
   function automatic pwmpt_pkg::pwmpt_result_type predict_ticks(logic [23:0] per,
                                                                 logic [23:0] pul);
      pwmpt_pkg::pwmpt_result_type r;
      logic [63:0] pt, dt, sc;
      int p;
      for (p = 0; p < 8; p++) begin
         pt = (64'(per) * 64'(model_clock_hz >> p)) / 64'd1000000;
         if (pt <= CNT_MAX || p == 7) break;
      end
      if (pt < 1) pt = 1;
      if (pt > CNT_MAX) pt = CNT_MAX;
      dt = (64'(pul) * 64'(model_clock_hz >> p)) / 64'd1000000;
      if (dt > pt) dt = pt;
      sc = (dt * 64'd65535) / pt;
      r.prescale_log2    = 3'(p);
      r.period_ticks     = pt[15:0];
      r.duty_ticks       = dt[15:0];
      r.duty_scaled      = sc[15:0];
      r.prescale_changed = (3'(p) != model_prescale);
      model_prescale = 3'(p);
      return r;
   endfunction

   // Cycle limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Result side: bursts of stalls, check against oldest expectation
   always @(posedge clock) begin
      pwmpt_pkg::pwmpt_result_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_prescale_log2, rsp_period_ticks, rsp_duty_ticks, rsp_duty_scaled,
                 rsp_prescale_changed};
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %p", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
      if (rsp_idle_off) begin
         rsp_ready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_gap = $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == REG_SOURCE_CLOCK) model_clock_hz = data[27:0];
      @(posedge clock);
   endtask

   // Send one request; exp_given means the row carries a typed-in result
   task automatic send_request(logic [23:0] per, logic [23:0] pul, bit idle,
                               bit exp_given = 0,
                               pwmpt_pkg::pwmpt_result_type exp_r = '0);
      pwmpt_pkg::pwmpt_result_type r;
      int gap;
      if (idle && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1; req_period_micros <= per; req_pulse_micros <= pul;
      do @(posedge clock); while (!req_ready);
      r = predict_ticks(per, pul);
      if (exp_given && r !== exp_r) begin
         mismatches++;
         if (mismatches <= 10) $display("table row disagrees: %p vs %p", exp_r, r);
      end
      expected_q.push_back(exp_given ? exp_r : r);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   // Directed table: period, pulse, typed expectation flag and value
   typedef struct {
      logic [23:0] per;
      logic [23:0] pul;
      bit          has_exp;
      pwmpt_pkg::pwmpt_result_type exp_r;
   } stim_row_type;

   stim_row_type table_rows[$];
   logic [27:0] clk_settings[$] = '{28'd1, 28'hFFFFFFF, 28'd250000000, 28'd0, 28'd1000000};

   initial begin
      int i, k;
      logic [23:0] per, pul;
      model_clock_hz = 28'd48000000;
      model_prescale = 3'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero period clamps to one tick; huge period saturates at last prescaler
      table_rows.push_back('{24'd0, 24'd0, 1, '{3'd0, 16'd1, 16'd0, 16'd0, 1'b0}});
      table_rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 1,
                             '{3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1}});
      table_rows.push_back('{24'd1000, 24'd500, 1, '{3'd0, 16'd48000, 16'd24000, 16'd32767, 1'b1}});
      table_rows.push_back('{24'd1000, 24'hFFFFFF, 1,
                             '{3'd0, 16'd48000, 16'd48000, 16'hFFFF, 1'b0}});
      table_rows.push_back('{24'd20000, 24'd1500, 0, '0});
      table_rows.push_back('{24'd1, 24'd0, 0, '0});
      table_rows.push_back('{24'd1365, 24'd1365, 0, '0});
      table_rows.push_back('{24'd1366, 24'd1, 0, '0});
      table_rows.push_back('{24'h555555, 24'hAAAAAA, 0, '0});
      table_rows.push_back('{24'hAAAAAA, 24'h555555, 0, '0});
      foreach (table_rows[j])
         send_request(table_rows[j].per, table_rows[j].pul, 0,
                      table_rows[j].has_exp, table_rows[j].exp_r);
      drain();

      // Clock register extremes with a few requests each
      foreach (clk_settings[j]) begin
         csr_write(REG_SOURCE_CLOCK, {4'(j), clk_settings[j]});
         send_request(24'd0, 24'd0, 0);
         send_request(24'hFFFFFF, 24'hFFFFFF, 0);
         send_request(24'd1000, 24'd999, 0);
         drain();
      end

      // Random part, clock register changed between phases
      for (i = 0; i < N_RANDOM; i++) begin
         if (i % 300 == 0) begin
            drain();
            csr_write(REG_SOURCE_CLOCK, (i == 0) ? 32'd48000000 : 32'($urandom));
            if ($urandom_range(0, 1))
               csr_write(REG_SOURCE_CLOCK, 32'($urandom_range(1, 250000000)));
         end
         k = $urandom_range(0, 9);
         if (k < 4) per = 24'($urandom_range(1, 100000));
         else if (k < 6) per = 24'($urandom_range(0, 1 << ($urandom_range(0, 24))));
         else per = 24'($urandom);
         if ($urandom_range(0, 2) == 0) pul = 24'($urandom);
         else pul = (per == 0) ? 24'd0 : 24'($urandom_range(0, per));
         if (i > N_RANDOM - 150) rsp_idle_off = 1'b1;
         send_request(per, pul, i < N_RANDOM - 150);
      end

      drain();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
